[hdl/gdd_pkg.sv]
// Shared constants and widths for the grid detection decode unit.
package gdd_pkg;

    localparam int MAX_SIDE    = 16;
    localparam int MAX_CLASSES = 32;
    localparam int CELL_BITS   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CLS_BITS    = $clog2(MAX_CLASSES);
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE * MAX_CLASSES;
    localparam int ADDR_BITS   = CELL_BITS + CLS_BITS;

    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 96;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H     = 3'd6;

    localparam logic KIND_CLASS = 1'b0;
    localparam logic KIND_BOX   = 1'b1;

    localparam int PIX_W      = 17;
    localparam int DIV_W      = 22;
    localparam int CELL_DIV_W = 8;

endpackage

[hdl/grid_detection_decode_unit.sv]
// Grid detection decode: class store, per-cell class scan and box conversion.
//
//  channel   | direction | transaction carries
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | class probability write or box item to decode
//  m_axis    | out       | class_id, score and box of one detection
//  cfg       | in        | one register write (index, data)
//
// A class item is written into the store as it is accepted and leaves the input ready.
// A box item holds the input through the scan of the store's single read port, then
// the multiply states ST_MUL1 and ST_MUL2 and the shift-subtract divider for the
// centers; raw mode and scores below threshold skip the multiply and divide.
// The store is not cleared by reset; rst_n clears the control and config state.
// A result waiting on m_axis does not stop new items; the next result stalls.
module grid_detection_decode_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cell_req[7:0], class_index[12:8], prob[28:13], box_x[44:29],
    // box_y[60:45], box_w[76:61], box_h[92:77], zero pad
    input  logic [gdd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // class_id[4:0], score[20:5], center_x[37:21], center_y[54:38],
    // width[71:55], height[88:72], zero pad
    output logic [gdd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gdd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gdd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [gdd_pkg::PIX_W-1:0] sat_pix(input logic [gdd_pkg::DIV_W-1:0] v);
        sat_pix = (|v[gdd_pkg::DIV_W-1:gdd_pkg::PIX_W]) ? '1 : v[gdd_pkg::PIX_W-1:0];
    endfunction

    // Input field unpacking
    logic [7:0]  in_cell;
    logic [4:0]  in_cls;
    logic [15:0] in_prob, in_bx, in_by, in_bw, in_bh;
    assign in_cell = s_axis_tdata[7:0];
    assign in_cls  = s_axis_tdata[12:8];
    assign in_prob = s_axis_tdata[28:13];
    assign in_bx   = s_axis_tdata[44:29];
    assign in_by   = s_axis_tdata[60:45];
    assign in_bw   = s_axis_tdata[76:61];
    assign in_bh   = s_axis_tdata[92:77];

    // Configuration registers
    logic [4:0]  grid_side_reg;
    logic [5:0]  class_count_reg;
    logic [15:0] score_threshold_reg;
    logic        square_size_mode_reg;
    logic        raw_mode_reg;
    logic [13:0] image_width_reg;
    logic [13:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg        <= 5'd7;
            class_count_reg      <= 6'd20;
            score_threshold_reg  <= 16'd13107;
            square_size_mode_reg <= 1'b1;
            raw_mode_reg         <= 1'b0;
            image_width_reg      <= 14'd448;
            image_height_reg     <= 14'd448;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gdd_pkg::REG_GRID_SIDE:   grid_side_reg        <= cfg_data[4:0];
                gdd_pkg::REG_CLASS_COUNT: class_count_reg      <= cfg_data[5:0];
                gdd_pkg::REG_THRESHOLD:   score_threshold_reg  <= cfg_data;
                gdd_pkg::REG_SQUARE_MODE: square_size_mode_reg <= cfg_data[0];
                gdd_pkg::REG_RAW_MODE:    raw_mode_reg         <= cfg_data[0];
                gdd_pkg::REG_IMAGE_W:     image_width_reg      <= cfg_data[13:0];
                gdd_pkg::REG_IMAGE_H:     image_height_reg     <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Clamped side and class count
    logic [4:0] side_c;
    logic [5:0] count_c;
    logic [9:0] side_sq;
    always_comb
    begin
        if (grid_side_reg == 5'd0)
            side_c = 5'd1;
        else if (grid_side_reg > 5'(gdd_pkg::MAX_SIDE))
            side_c = 5'(gdd_pkg::MAX_SIDE);
        else
            side_c = grid_side_reg;
        if (class_count_reg == 6'd0)
            count_c = 6'd1;
        else if (class_count_reg > 6'(gdd_pkg::MAX_CLASSES))
            count_c = 6'(gdd_pkg::MAX_CLASSES);
        else
            count_c = class_count_reg;
        side_sq = 10'(side_c) * 10'(side_c);
    end

    state_t state_reg;

    logic in_accept;
    logic box_accept;
    logic cell_in_grid;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign box_accept    = in_accept && (s_axis_tuser == gdd_pkg::KIND_BOX);
    assign cell_in_grid  = {2'b00, in_cell} < side_sq;

    // Latched box item
    logic [gdd_pkg::CELL_BITS-1:0] cell_reg;
    logic [15:0] obj_reg, bx_reg, by_reg, bw_reg, bh_reg;

    // Scan pipeline: read issue, read data, product, compare
    logic [5:0]  scan_j_reg;
    logic        rd_v_reg;
    logic [gdd_pkg::CLS_BITS-1:0] rd_cls_reg;
    logic [15:0] rd_data_reg;
    logic        prod_v_reg;
    logic [gdd_pkg::CLS_BITS-1:0] prod_cls_reg;
    logic [31:0] prod_reg;
    logic [31:0] best_prod_reg;
    logic [gdd_pkg::CLS_BITS-1:0] best_cls_reg;
    logic        issue;
    logic [gdd_pkg::ADDR_BITS-1:0] rd_addr, wr_addr;
    logic        wr_en;

    assign issue   = (state_reg == ST_SCAN) && (scan_j_reg < count_c);
    assign rd_addr = {cell_reg, scan_j_reg[gdd_pkg::CLS_BITS-1:0]};
    assign wr_addr = {in_cell[gdd_pkg::CELL_BITS-1:0], in_cls[gdd_pkg::CLS_BITS-1:0]};
    assign wr_en   = in_accept && (s_axis_tuser == gdd_pkg::KIND_CLASS);

    logic [15:0] class_prob_store [gdd_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            class_prob_store[wr_addr] <= in_prob;
        rd_data_reg <= class_prob_store[rd_addr];
    end

    // Cell to row and column, one quotient bit per cycle
    logic [gdd_pkg::CELL_DIV_W-1:0] cdvd_reg;
    logic [3:0] crem_reg;
    logic [3:0] ccnt_reg;
    logic [4:0] ctrial;
    logic       cge;
    logic [3:0] crem_next;
    assign ctrial    = {crem_reg, cdvd_reg[gdd_pkg::CELL_DIV_W-1]};
    assign cge       = ctrial >= side_c;
    assign crem_next = cge ? 4'(ctrial - side_c) : ctrial[3:0];

    // Center dividers, two lanes sharing one step counter
    logic [gdd_pkg::DIV_W-1:0] dvx_reg, dvy_reg;
    logic [3:0]  remx_reg, remy_reg;
    logic [4:0]  dcnt_reg;
    logic [4:0]  xtrial, ytrial;
    logic        xge, yge;
    logic [3:0]  remx_next, remy_next;
    assign xtrial    = {remx_reg, dvx_reg[gdd_pkg::DIV_W-1]};
    assign ytrial    = {remy_reg, dvy_reg[gdd_pkg::DIV_W-1]};
    assign xge       = xtrial >= side_c;
    assign yge       = ytrial >= side_c;
    assign remx_next = xge ? 4'(xtrial - side_c) : xtrial[3:0];
    assign remy_next = yge ? 4'(ytrial - side_c) : ytrial[3:0];

    // Multiplies: cell-offset times image size, and extents
    logic [33:0] nx_full, ny_full;
    logic [31:0] sqw_reg, sqh_reg;
    logic [31:0] ext_w_op, ext_h_op;
    logic [45:0] ew_full, eh_full;
    logic [17:0] ew_val, eh_val;
    logic [gdd_pkg::PIX_W-1:0] ew_reg, eh_reg;
    assign nx_full  = {crem_reg, bx_reg} * {20'd0, image_width_reg};
    assign ny_full  = {cdvd_reg[3:0], by_reg} * {20'd0, image_height_reg};
    assign ext_w_op = square_size_mode_reg ? sqw_reg : {16'd0, bw_reg};
    assign ext_h_op = square_size_mode_reg ? sqh_reg : {16'd0, bh_reg};
    assign ew_full  = {14'd0, ext_w_op} * {32'd0, image_width_reg};
    assign eh_full  = {14'd0, ext_h_op} * {32'd0, image_height_reg};
    assign ew_val   = square_size_mode_reg ? ew_full[45:28] : ew_full[29:12];
    assign eh_val   = square_size_mode_reg ? eh_full[45:28] : eh_full[29:12];

    logic scan_done;
    assign scan_done = (scan_j_reg == count_c) && !rd_v_reg && !prod_v_reg
                       && (ccnt_reg == 4'(gdd_pkg::CELL_DIV_W));

    logic [gdd_pkg::OUT_DATA_W-1:0] result;
    always_comb
    begin
        result = '0;
        result[4:0]  = best_cls_reg;
        result[20:5] = best_prod_reg[31:16];
        if (raw_mode_reg)
        begin
            result[37:21] = {1'b0, bx_reg};
            result[54:38] = {1'b0, by_reg};
            result[71:55] = {1'b0, bw_reg};
            result[88:72] = {1'b0, bh_reg};
        end
        else
        begin
            result[37:21] = sat_pix(dvx_reg);
            result[54:38] = sat_pix(dvy_reg);
            result[71:55] = ew_reg;
            result[88:72] = eh_reg;
        end
    end

    logic m_tvalid_reg;
    logic [gdd_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            scan_j_reg    <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            ccnt_reg      <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            // In ST_OUT the output register is loaded whenever it drains.
            if (m_axis_tready && state_reg != ST_OUT)
                m_tvalid_reg <= 1'b0;

            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (box_accept && cell_in_grid)
                    begin
                        scan_j_reg <= '0;
                        ccnt_reg   <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                        scan_j_reg <= scan_j_reg + 6'd1;
                    if (ccnt_reg != 4'(gdd_pkg::CELL_DIV_W))
                        ccnt_reg <= ccnt_reg + 4'd1;
                    if (scan_done)
                    begin
                        if (best_prod_reg[31:16] < score_threshold_reg)
                            state_reg <= ST_IDLE;
                        else if (raw_mode_reg)
                            state_reg <= ST_OUT;
                        else
                            state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                    state_reg <= ST_MUL2;
                ST_MUL2:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'(gdd_pkg::DIV_W - 1))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_axis_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (box_accept)
        begin
            cell_reg <= in_cell[gdd_pkg::CELL_BITS-1:0];
            obj_reg  <= in_prob;
            bx_reg   <= in_bx;
            by_reg   <= in_by;
            bw_reg   <= in_bw;
            bh_reg   <= in_bh;
            cdvd_reg <= in_cell;
            crem_reg <= '0;
        end
        else if (state_reg == ST_SCAN && ccnt_reg != 4'(gdd_pkg::CELL_DIV_W))
        begin
            crem_reg <= crem_next;
            cdvd_reg <= {cdvd_reg[gdd_pkg::CELL_DIV_W-2:0], cge};
        end

        rd_cls_reg   <= scan_j_reg[gdd_pkg::CLS_BITS-1:0];
        prod_cls_reg <= rd_cls_reg;
        prod_reg     <= {16'd0, obj_reg} * {16'd0, rd_data_reg};

        // The first class always loads; later ones replace only when strictly larger.
        if (prod_v_reg && (prod_cls_reg == '0 || prod_reg > best_prod_reg))
        begin
            best_prod_reg <= prod_reg;
            best_cls_reg  <= prod_cls_reg;
        end

        if (state_reg == ST_MUL1)
        begin
            // After the cell division, crem holds the column and cdvd the row.
            dvx_reg  <= nx_full[33:12];
            dvy_reg  <= ny_full[33:12];
            remx_reg <= '0;
            remy_reg <= '0;
            sqw_reg  <= {16'd0, bw_reg} * {16'd0, bw_reg};
            sqh_reg  <= {16'd0, bh_reg} * {16'd0, bh_reg};
        end
        else if (state_reg == ST_DIV)
        begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            dvx_reg  <= {dvx_reg[gdd_pkg::DIV_W-2:0], xge};
            dvy_reg  <= {dvy_reg[gdd_pkg::DIV_W-2:0], yge};
        end

        if (state_reg == ST_MUL2)
        begin
            ew_reg <= sat_pix({4'd0, ew_val});
            eh_reg <= sat_pix({4'd0, eh_val});
        end
    end

endmodule

[hdl/gdd_checker.sv]
// Port-level assertions for the grid detection decode unit, with its bind.
module gdd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [gdd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic box_in;
    logic class_in;
    assign box_in   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == gdd_pkg::KIND_BOX);
    assign class_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == gdd_pkg::KIND_CLASS);

    // A class write never makes the block busy.
    a_class_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        class_in |=> s_axis_tready)
        else $error("input stalled after a class write");

    // A result cannot appear in the cycle right after a box item enters.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        box_in |=> !$rose(m_axis_tvalid))
        else $error("result appeared too soon after a box item");

    // A result never appears without a scan having run: the input was busy the cycle before.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind grid_detection_decode_unit gdd_checker u_gdd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tb.sv]
// Self-checking testbench for the grid detection decode unit.
module tb;

    typedef struct packed {
        logic        hold;
        logic        kind;
        logic [7:0]  cell_idx;
        logic [4:0]  cls;
        logic [15:0] prob;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bw;
        logic [15:0] bh;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  class_id;
        logic [15:0] score;
        logic [16:0] cx;
        logic [16:0] cy;
        logic [16:0] wd;
        logic [16:0] ht;
    } det_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [gdd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [gdd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gdd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gdd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    grid_detection_decode_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies, kept in step with the transactions on the cfg channel.
    logic [4:0]  side_reg   = 5'd7;
    logic [5:0]  count_reg  = 6'd20;
    logic [15:0] thr_reg    = 16'd13107;
    logic        square_reg = 1'b1;
    logic        raw_reg    = 1'b0;
    logic [13:0] img_w_reg  = 14'd448;
    logic [13:0] img_h_reg  = 14'd448;

    logic [15:0] prob_store [0:gdd_pkg::STORE_DEPTH-1];
    bit          prob_written [0:gdd_pkg::STORE_DEPTH-1];

    in_item_t pending_items[$];
    det_t     detections[$];
    in_item_t cur_item;
    bit       item_taken = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned pushed = 0;
    int unsigned mismatches = 0;
    int unsigned n_class = 0;
    int unsigned n_box = 0;
    int unsigned n_det = 0;
    int unsigned n_settings = 0;

    function automatic int unsigned eff_side();
        if (side_reg == 0)
            return 1;
        if (side_reg > gdd_pkg::MAX_SIDE)
            return gdd_pkg::MAX_SIDE;
        return side_reg;
    endfunction

    function automatic int unsigned eff_count();
        if (count_reg == 0)
            return 1;
        if (count_reg > gdd_pkg::MAX_CLASSES)
            return gdd_pkg::MAX_CLASSES;
        return count_reg;
    endfunction

    function automatic logic [16:0] clip_pix(input logic [63:0] v);
        if (v > 64'd131071)
            return 17'h1FFFF;
        return v[16:0];
    endfunction

    function automatic logic [16:0] center_of(input logic [15:0] frac, input int unsigned pos,
                                              input int unsigned side, input logic [13:0] size);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] pos64;
        pos64 = 64'(pos);
        num = 64'(frac);
        num = (num + (pos64 << 16)) * 64'(size);
        den = 64'(side);
        den = den * 64'd4096;
        return clip_pix(num / den);
    endfunction

    function automatic logic [16:0] extent_of(input logic [15:0] frac, input logic [13:0] size);
        logic [63:0] f;
        f = 64'(frac);
        if (square_reg)
            return clip_pix((f * f * 64'(size)) >> 28);
        return clip_pix((f * 64'(size)) >> 12);
    endfunction

    // Scan the cell's classes and build the detection; returns 0 when nothing is emitted.
    function automatic bit decode_box(input in_item_t it, output det_t d);
        int unsigned side;
        int unsigned count;
        int unsigned j;
        int unsigned row;
        int unsigned col;
        logic [31:0] prod;
        logic [31:0] best;
        logic [4:0]  best_cls;
        side = eff_side();
        count = eff_count();
        d = '0;
        if (it.cell_idx >= side * side)
            return 0;
        best = '0;
        best_cls = '0;
        for (j = 0; j < count; j++)
        begin
            prod = 32'(it.prob) * 32'(prob_store[it.cell_idx * gdd_pkg::MAX_CLASSES + j]);
            // Strict compare keeps the lowest class on a tie.
            if (j == 0 || prod > best)
            begin
                best = prod;
                best_cls = 5'(j);
            end
        end
        if (best[31:16] < thr_reg)
            return 0;
        d.class_id = best_cls;
        d.score = best[31:16];
        if (raw_reg)
        begin
            d.cx = {1'b0, it.bx};
            d.cy = {1'b0, it.by};
            d.wd = {1'b0, it.bw};
            d.ht = {1'b0, it.bh};
        end
        else
        begin
            row = it.cell_idx / side;
            col = it.cell_idx % side;
            d.cx = center_of(it.bx, col, side, img_w_reg);
            d.cy = center_of(it.by, row, side, img_h_reg);
            d.wd = extent_of(it.bw, img_w_reg);
            d.ht = extent_of(it.bh, img_h_reg);
        end
        return 1;
    endfunction

    function automatic logic [15:0] rand_prob();
        logic [15:0] v;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            v = 16'($urandom_range(65535, 56000));
        else if (r < 45)
        begin
            // A small set of values makes equal products likely.
            case ($urandom_range(3))
                0: v = 16'd0;
                1: v = 16'hFFFF;
                2: v = 16'hC000;
                default: v = 16'hF000;
            endcase
        end
        else
            v = 16'($urandom);
        return v;
    endfunction

    function automatic logic [15:0] rand_box();
        logic [15:0] v;
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            v = 16'd0;
        else if (r == 1)
            v = 16'hFFFF;
        else
            v = 16'($urandom);
        return v;
    endfunction

    task automatic push_class(input logic [7:0] cell_idx, input logic [4:0] cls,
                              input logic [15:0] prob);
        in_item_t it;
        it.hold = 1'b0;
        it.kind = gdd_pkg::KIND_CLASS;
        it.cell_idx = cell_idx;
        it.cls = cls;
        it.prob = prob;
        it.bx = 16'($urandom);
        it.by = 16'($urandom);
        it.bw = 16'($urandom);
        it.bh = 16'($urandom);
        pending_items.push_back(it);
        prob_written[cell_idx * gdd_pkg::MAX_CLASSES + cls] = 1'b1;
        pushed++;
    endtask

    // Fills any class of the cell that the scan would read before it was written.
    task automatic push_box(input logic [7:0] cell_idx, input logic [15:0] obj,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic [15:0] h, input bit hold);
        in_item_t it;
        int unsigned j;
        if (cell_idx < eff_side() * eff_side())
        begin
            for (j = 0; j < eff_count(); j++)
            begin
                if (!prob_written[cell_idx * gdd_pkg::MAX_CLASSES + j])
                    push_class(cell_idx, 5'(j), rand_prob());
            end
        end
        it.hold = hold;
        it.kind = gdd_pkg::KIND_BOX;
        it.cell_idx = cell_idx;
        it.cls = 5'($urandom);
        it.prob = obj;
        it.bx = x;
        it.by = y;
        it.bw = w;
        it.bh = h;
        pending_items.push_back(it);
        pushed++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || detections.size() != 0)
            @(posedge clk);
        // Boxes that give no result may still be in the scan.
        repeat (100) @(posedge clk);
    endtask

    // Bits above the register width carry random junk that the block must drop.
    task automatic write_reg(input logic [gdd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val,
                             input int w);
        logic [15:0] keep;
        logic [15:0] junk;
        logic [15:0] word;
        keep = (w >= 16) ? 16'hFFFF : ((16'h1 << w) - 16'h1);
        junk = 16'($urandom);
        word = (val & keep) | (junk & ~keep);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            gdd_pkg::REG_GRID_SIDE:   side_reg = word[4:0];
            gdd_pkg::REG_CLASS_COUNT: count_reg = word[5:0];
            gdd_pkg::REG_THRESHOLD:   thr_reg = word;
            gdd_pkg::REG_SQUARE_MODE: square_reg = word[0];
            gdd_pkg::REG_RAW_MODE:    raw_reg = word[0];
            gdd_pkg::REG_IMAGE_W:     img_w_reg = word[13:0];
            gdd_pkg::REG_IMAGE_H:     img_h_reg = word[13:0];
            default: ;
        endcase
    endtask

    task automatic run_setting(input logic [15:0] side, input logic [15:0] count,
                               input logic [15:0] thr, input logic [15:0] square,
                               input logic [15:0] raw, input logic [15:0] img_w,
                               input logic [15:0] img_h, input int unsigned n,
                               input bit hold);
        int unsigned start;
        int unsigned r;
        int unsigned cells;
        int unsigned span;
        int unsigned cell_idx;
        bit held;
        bit hold_now;
        wait_idle();
        write_reg(gdd_pkg::REG_GRID_SIDE, side, 5);
        write_reg(gdd_pkg::REG_CLASS_COUNT, count, 6);
        write_reg(gdd_pkg::REG_THRESHOLD, thr, 16);
        write_reg(gdd_pkg::REG_SQUARE_MODE, square, 1);
        write_reg(gdd_pkg::REG_RAW_MODE, raw, 1);
        write_reg(gdd_pkg::REG_IMAGE_W, img_w, 14);
        write_reg(gdd_pkg::REG_IMAGE_H, img_h, 14);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
        start = pushed;
        held = 1'b0;
        while (pushed - start < n)
        begin
            r = $urandom_range(99);
            cells = eff_side() * eff_side();
            span = (cells < 6) ? cells : 6;
            // Most boxes go to a few cells so that their classes are written once.
            cell_idx = ($urandom_range(9) == 0) ? $urandom_range(cells - 1)
                                                 : $urandom_range(span - 1);
            if (r < 12)
                push_class(8'($urandom_range(255)), 5'($urandom_range(31)), 16'($urandom));
            else if (r < 24)
                push_class(8'(cell_idx), 5'($urandom_range(eff_count() - 1)), rand_prob());
            else if (r < 32 && cells < 256)
                push_box(8'($urandom_range(255, cells)), rand_prob(), rand_box(), rand_box(),
                         rand_box(), rand_box(), 1'b0);
            else
            begin
                hold_now = hold && !held && (pushed - start >= n / 2);
                push_box(8'(cell_idx), rand_prob(), rand_box(), rand_box(), rand_box(),
                         rand_box(), hold_now);
                if (hold_now)
                    held = 1'b1;
            end
        end
    endtask

    always @(negedge clk)
    begin : drive_items
        if (rst_n)
        begin
            if (!s_axis_tvalid || item_taken)
            begin
                if (pending_items.size() != 0
                    && !(pending_items[0].hold && detections.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, cur_item.bh, cur_item.bw, cur_item.by,
                                     cur_item.bx, cur_item.prob, cur_item.cls,
                                     cur_item.cell_idx};
                    s_axis_tuser <= cur_item.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watch_ports
        det_t exp_d;
        det_t got_d;
        item_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n && item_taken)
        begin
            if (cur_item.kind == gdd_pkg::KIND_CLASS)
            begin
                prob_store[cur_item.cell_idx * gdd_pkg::MAX_CLASSES + cur_item.cls]
                    = cur_item.prob;
                n_class++;
            end
            else
            begin
                n_box++;
                if (decode_box(cur_item, exp_d))
                    detections.push_back(exp_d);
            end
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_d.class_id = m_axis_tdata[4:0];
            got_d.score = m_axis_tdata[20:5];
            got_d.cx = m_axis_tdata[37:21];
            got_d.cy = m_axis_tdata[54:38];
            got_d.wd = m_axis_tdata[71:55];
            got_d.ht = m_axis_tdata[88:72];
            if (detections.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected detection: class %0d score %0d box %0d %0d %0d %0d",
                             got_d.class_id, got_d.score, got_d.cx, got_d.cy,
                             got_d.wd, got_d.ht);
            end
            else
            begin
                exp_d = detections.pop_front();
                n_det++;
                if (got_d.class_id !== exp_d.class_id || got_d.score !== exp_d.score
                    || got_d.cx !== exp_d.cx || got_d.cy !== exp_d.cy
                    || got_d.wd !== exp_d.wd || got_d.ht !== exp_d.ht)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected class %0d score %0d box %0d %0d %0d %0d",
                                 exp_d.class_id, exp_d.score, exp_d.cx, exp_d.cy,
                                 exp_d.wd, exp_d.ht);
                        $display("          actual   class %0d score %0d box %0d %0d %0d %0d",
                                 got_d.class_id, got_d.score, got_d.cx, got_d.cy,
                                 got_d.wd, got_d.ht);
                    end
                end
            end
        end
    end

    initial
    begin : run_test
        int unsigned j;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 56;

        // Directed part at the reset settings: ties, threshold edge, box extremes,
        // cells outside the grid and the largest class write fields.
        for (j = 0; j < 20; j++)
            push_class(8'd0, 5'(j), (j == 7 || j == 19) ? 16'hFFFF
                                    : ((j == 0) ? 16'd0 : 16'($urandom_range(1000))));
        push_box(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_box(8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        push_box(8'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        push_box(8'd0, 16'd13107, rand_box(), rand_box(), rand_box(), rand_box(), 1'b0);
        push_box(8'd0, 16'd13108, rand_box(), rand_box(), rand_box(), rand_box(), 1'b0);
        push_box(8'd49, 16'hFFFF, rand_box(), rand_box(), rand_box(), rand_box(), 1'b0);
        push_box(8'd255, 16'hFFFF, rand_box(), rand_box(), rand_box(), rand_box(), 1'b0);
        push_class(8'd255, 5'd31, 16'hFFFF);

        run_setting(4, 4, 13107, 1, 0, 0, 448, 165, 1'b0);
        run_setting(16, 2, 0, 0, 0, 8192, 8192, 165, 1'b1);
        run_setting(0, 63, 20000, 1, 0, 16383, 1, 120, 1'b0);

        send_idle_pct = 56;
        recv_idle_pct = 18;
        run_setting(31, 1, 0, 0, 1, 640, 480, 165, 1'b1);
        run_setting(1, 0, 65535, 1, 0, 1, 8192, 60, 1'b0);
        run_setting(7, 20, 13107, 1, 0, 448, 448, 165, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(5, 8, 30000, 0, 0, 1, 8192, 165, 1'b1);
        run_setting(12, 6, 16'($urandom_range(40000)), 1, 1, 16'($urandom_range(8192)),
                    16'($urandom_range(8192)), 165, 1'b0);
        run_setting(16, 3, 1000, 1, 0, 8192, 448, 165, 1'b0);

        wait_idle();

        $display("Covered %0d class writes and %0d box items over %0d register settings,",
                 n_class, n_box, 1 + n_settings);
        $display("with %0d detections checked and %0d mismatches.", n_det, mismatches);
        if (mismatches == 0 && detections.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #8000000;
        $display("timeout with %0d detections outstanding", detections.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hdl/gdd_pkg.sv
hdl/grid_detection_decode_unit.sv
hdl/gdd_checker.sv
bench/tb.sv
